FILE: src/rbnh_pkg.sv
// Package for the ray box nearest hit core: payload structs, the job record
// passed from the front end to the back end, register indexes and FSM states.
// No dependencies.
package rbnh_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISTANCE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PARALLEL_THRESHOLD = 2'd1;

  localparam logic [14:0] MAX_DISTANCE_RST       = 15'd8000;
  localparam logic [14:0] PARALLEL_THRESHOLD_RST = 15'd1;

  localparam logic signed [15:0] T_LOW  = -16'sd32768;
  localparam logic signed [15:0] T_HIGH = 16'sd32767;

  typedef struct packed {
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] wall_x;
    logic signed [15:0] wall_y;
    logic [14:0]        wall_w;
    logic [14:0]        wall_h;
    logic               first_wall;
    logic               last_wall;
  } in_t;

  typedef struct packed {
    logic [14:0] closest_distance;
    logic        any_hit;
  } out_t;

  // Edge differences in order: x low, x high, y low, y high.
  typedef struct packed {
    logic [3:0][17:0]   diff;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic               par_x;
    logic               par_y;
    logic               par_miss;
    logic               first_wall;
    logic               last_wall;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_WAIT,
    ST_EVAL,
    ST_OUT
  } back_state_t;

endpackage

FILE: src/rbnh_front.sv
// Front end: classifies one wall against the ray and builds the job record.
// Depends on rbnh_pkg.
module rbnh_front (
  input  rbnh_pkg::in_t  item,
  input  logic [14:0]    parallel_threshold,
  output rbnh_pkg::job_t job
);

  logic signed [17:0] ox, oy, lox, loy, hix, hiy;
  logic [15:0] magx, magy;
  logic parx, pary, missx, missy;

  always_comb begin
    ox  = 18'(item.origin_x);
    oy  = 18'(item.origin_y);
    lox = 18'(item.wall_x);
    loy = 18'(item.wall_y);
    hix = lox + $signed({3'b000, item.wall_w});
    hiy = loy + $signed({3'b000, item.wall_h});
    magx = item.dir_x[15] ? 16'(-item.dir_x) : 16'(item.dir_x);
    magy = item.dir_y[15] ? 16'(-item.dir_y) : 16'(item.dir_y);
    parx = (magx == 16'd0) || (magx < {1'b0, parallel_threshold});
    pary = (magy == 16'd0) || (magy < {1'b0, parallel_threshold});
    missx = parx && ((ox < lox) || (ox > hix));
    missy = pary && ((oy < loy) || (oy > hiy));

    job.diff[0]    = 18'(lox - ox);
    job.diff[1]    = 18'(hix - ox);
    job.diff[2]    = 18'(loy - oy);
    job.diff[3]    = 18'(hiy - oy);
    job.dir_x      = item.dir_x;
    job.dir_y      = item.dir_y;
    job.par_x      = parx;
    job.par_y      = pary;
    job.par_miss   = missx || missy;
    job.first_wall = item.first_wall;
    job.last_wall  = item.last_wall;
  end

endmodule

FILE: src/rbnh_queue.sv
// Two-entry transaction queue between the front end and the back end.
// Depends on rbnh_pkg.
module rbnh_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rbnh_pkg::job_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output rbnh_pkg::job_t pop_data
);

  rbnh_pkg::job_t mem_r [2];
  logic wptr_r, rptr_r;
  logic [1:0] count_r;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign pop_data  = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= ~wptr_r;
      end
      if (pop) begin
        rptr_r <= ~rptr_r;
      end
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: src/rbnh_div.sv
// Iterative floor divider: (diff << DIR_FRAC_BITS) / dir, saturated to 16 bits.
// One quotient bit per cycle after a range check. Depends on rbnh_pkg.
module rbnh_div #(
  parameter int DIR_FRAC_BITS = 14
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [17:0] diff,
  input  logic signed [15:0] dir,
  output logic               done,
  output logic signed [15:0] quot
);

  localparam int AW = 17 + DIR_FRAC_BITS;
  localparam int W  = (AW > 32) ? AW : 32;

  logic [W-1:0] rem_r, dsh_r;
  logic [15:0]  q_r;
  logic [3:0]   cnt_r;
  logic         busy_r, done_r, neg_r, ovf_r;

  logic [16:0]   amag;
  logic [15:0]   dmag;
  logic [AW-1:0] anum;
  logic          ge;
  logic [17:0]   qv;

  always_comb begin
    amag = diff[17] ? 17'(-diff) : 17'(diff);
    dmag = dir[15] ? 16'(-dir) : 16'(dir);
    anum = {amag, {DIR_FRAC_BITS{1'b0}}};
    ge   = (rem_r >= dsh_r);
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= W'(anum);
      dsh_r <= W'({dmag, 15'd0});
      neg_r <= diff[17] ^ dir[15];
      ovf_r <= ({1'b0, W'(anum)} >= (W + 1)'({dmag, 16'd0}));
      q_r   <= 16'd0;
      cnt_r <= 4'd15;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - dsh_r;
      end
      q_r   <= {q_r[14:0], ge};
      dsh_r <= dsh_r >> 1;
      cnt_r <= cnt_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == 4'd0);
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == 4'd0)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_comb begin
    qv = {2'b00, q_r} + {17'd0, (rem_r != '0)};
    if (ovf_r) begin
      quot = neg_r ? rbnh_pkg::T_LOW : rbnh_pkg::T_HIGH;
    end else if (neg_r) begin
      quot = (qv > 18'd32768) ? rbnh_pkg::T_LOW : 16'(-qv);
    end else begin
      quot = (q_r > 16'd32767) ? rbnh_pkg::T_HIGH : q_r;
    end
  end

  assign done = done_r;

endmodule

FILE: src/rbnh_back.sv
// Back end: runs the slab divisions for one job, folds in the nearest hit and
// holds the result register. Depends on rbnh_pkg and rbnh_div.
module rbnh_back #(
  parameter int DIR_FRAC_BITS = 14
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           job_valid,
  input  rbnh_pkg::job_t job,
  output logic           job_pop,
  input  logic [14:0]    max_distance,
  output logic           out_valid,
  output rbnh_pkg::out_t out_data,
  input  logic           out_stall
);

  rbnh_pkg::back_state_t state_r, state_nxt;
  rbnh_pkg::job_t job_r;
  logic [1:0] k_r, k_nxt;
  logic signed [15:0] tmin_r, tmin_nxt, tmax_r, tmax_nxt, t1_r, t1_nxt;
  logic [14:0] nearest_r, nearest_nxt;
  logic hit_r, hit_nxt;
  logic out_valid_r, out_valid_nxt;
  rbnh_pkg::out_t out_data_r, out_data_nxt;

  logic div_start, div_done;
  logic signed [15:0] div_q;
  logic signed [17:0] sel_diff;
  logic signed [15:0] sel_dir, near_t, far_t, hit_dist;
  logic sel_par, out_free, hit_ok;

  assign sel_diff = $signed(job_r.diff[k_r]);
  assign sel_dir  = k_r[1] ? job_r.dir_y : job_r.dir_x;
  assign sel_par  = k_r[1] ? job_r.par_y : job_r.par_x;
  assign out_free = !out_valid_r || !out_stall;

  rbnh_div #(.DIR_FRAC_BITS(DIR_FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .diff  (sel_diff),
    .dir   (sel_dir),
    .done  (div_done),
    .quot  (div_q)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rbnh_pkg::ST_IDLE: begin
        if (job_valid) begin
          state_nxt = rbnh_pkg::ST_START;
        end
      end
      rbnh_pkg::ST_START: begin
        if (!sel_par) begin
          state_nxt = rbnh_pkg::ST_WAIT;
        end else if (k_r == 2'd3) begin
          state_nxt = rbnh_pkg::ST_EVAL;
        end
      end
      rbnh_pkg::ST_WAIT: begin
        if (div_done) begin
          state_nxt = (k_r == 2'd3) ? rbnh_pkg::ST_EVAL : rbnh_pkg::ST_START;
        end
      end
      rbnh_pkg::ST_EVAL: begin
        state_nxt = job_r.last_wall ? rbnh_pkg::ST_OUT : rbnh_pkg::ST_IDLE;
      end
      rbnh_pkg::ST_OUT: begin
        if (out_free) begin
          state_nxt = rbnh_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rbnh_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    job_pop       = 1'b0;
    div_start     = 1'b0;
    k_nxt         = k_r;
    tmin_nxt      = tmin_r;
    tmax_nxt      = tmax_r;
    t1_nxt        = t1_r;
    nearest_nxt   = nearest_r;
    hit_nxt       = hit_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    near_t        = (t1_r < div_q) ? t1_r : div_q;
    far_t         = (t1_r < div_q) ? div_q : t1_r;
    hit_ok        = !job_r.par_miss && !tmax_r[15] && !(tmin_r > tmax_r);
    hit_dist      = !tmin_r[15] ? tmin_r : tmax_r;
    case (state_r)
      rbnh_pkg::ST_IDLE: begin
        if (job_valid) begin
          job_pop  = 1'b1;
          k_nxt    = 2'd0;
          tmin_nxt = rbnh_pkg::T_LOW;
          tmax_nxt = rbnh_pkg::T_HIGH;
          if (job.first_wall) begin
            nearest_nxt = max_distance;
            hit_nxt     = 1'b0;
          end
        end
      end
      rbnh_pkg::ST_START: begin
        if (!sel_par) begin
          div_start = 1'b1;
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end
      rbnh_pkg::ST_WAIT: begin
        if (div_done) begin
          k_nxt = k_r + 2'd1;
          if (!k_r[0]) begin
            t1_nxt = div_q;
          end else begin
            if (near_t > tmin_r) begin
              tmin_nxt = near_t;
            end
            if (far_t < tmax_r) begin
              tmax_nxt = far_t;
            end
          end
        end
      end
      rbnh_pkg::ST_EVAL: begin
        if (hit_ok && !hit_dist[15] && (hit_dist[14:0] < nearest_r)) begin
          nearest_nxt = hit_dist[14:0];
          hit_nxt     = 1'b1;
        end
      end
      rbnh_pkg::ST_OUT: begin
        if (out_free) begin
          out_valid_nxt                 = 1'b1;
          out_data_nxt.closest_distance = nearest_r;
          out_data_nxt.any_hit          = hit_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      job_r <= job;
    end
    k_r        <= k_nxt;
    tmin_r     <= tmin_nxt;
    tmax_r     <= tmax_nxt;
    t1_r       <= t1_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rbnh_pkg::ST_IDLE;
      nearest_r   <= rbnh_pkg::MAX_DISTANCE_RST;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      nearest_r   <= nearest_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: src/ray_box_nearest_hit_core.sv
// Top level of the ray box nearest hit core: configuration registers, front
// end, job queue and back end. Depends on rbnh_pkg and all rbnh_* modules.
//
// Usage: each input transaction carries one ray and one wall rectangle. The
// ray is tested against the wall with the slab method, and the nearest hit
// below max_distance is kept across a run of walls. A transaction with
// first_wall set restarts the run; one with last_wall set produces exactly
// one output transaction holding the nearest distance and a hit flag.
// Transactions move when valid is high and stall is low on that channel.
// The back end takes one wall at a time: it accepts the job, then for each
// slab edge either skips it as parallel or starts the shared iterative
// divider and waits for its 16-bit quotient, then folds in the hit, and on
// a last wall hands the result to the output register. The divider range
// checks, then produces the quotient one bit at a time, then hands it off.
// A two-entry queue lets the front end keep accepting while the back end
// works, and the output register lets the back end finish a wall while a
// result waits to be taken. A stalled result holds the back end once it has
// the next result ready, and the queue then fills and raises in_stall.
// Reset (synchronous, rst_n low) empties the queue, drops any pending
// result and returns registers and the running state to their defaults.
// Configuration writes are always taken (cfg_ready is high); writes to an
// index beyond the register list are ignored.
module ray_box_nearest_hit_core #(
  parameter int DIR_FRAC_BITS = 14
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  rbnh_pkg::in_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output rbnh_pkg::out_t                out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rbnh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rbnh_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic [14:0] max_distance_r, parallel_threshold_r;
  rbnh_pkg::job_t front_job, queue_job;
  logic q_full, q_not_empty, q_pop, q_push;

  assign cfg_ready = 1'b1;

  // Configuration registers; only meant to change while the core is idle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_distance_r       <= rbnh_pkg::MAX_DISTANCE_RST;
      parallel_threshold_r <= rbnh_pkg::PARALLEL_THRESHOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rbnh_pkg::CFG_MAX_DISTANCE:       max_distance_r       <= cfg_wdata[14:0];
        rbnh_pkg::CFG_PARALLEL_THRESHOLD: parallel_threshold_r <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  // The front end classifies the wall in the cycle it is accepted.
  rbnh_front u_front (
    .item               (in_data),
    .parallel_threshold (parallel_threshold_r),
    .job                (front_job)
  );

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  rbnh_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (front_job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (queue_job)
  );

  rbnh_back #(.DIR_FRAC_BITS(DIR_FRAC_BITS)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .job_valid    (q_not_empty),
    .job          (queue_job),
    .job_pop      (q_pop),
    .max_distance (max_distance_r),
    .out_valid    (out_valid),
    .out_data     (out_data),
    .out_stall    (out_stall)
  );

endmodule
